// ----- rtl/core/vpa_pkg.sv -----
// Package for the variable partition allocator: table entry type, widths,
// command, status, policy and register codes, and the sequencer states.
// No dependencies.
`default_nettype none
package vpa_pkg;

   localparam int MAX_PARTITIONS = 64;
   localparam int IDX_BITS       = 6;
   localparam int CNT_BITS       = 7;
   localparam int ADDR_BITS      = 20;
   localparam int LEN_BITS       = 21;
   localparam int JOB_BITS       = 16;
   localparam int KB_BITS        = 11;
   localparam int KB_SHIFT       = 10;

   localparam logic [LEN_BITS-1:0] DEFAULT_MEMORY = 21'd102400;
   localparam logic [LEN_BITS-1:0] MEMORY_LIMIT   = 21'd1048576;
   localparam logic [CNT_BITS-1:0] TABLE_DEPTH    = 7'd64;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_SPACE   = 2'd1;
   localparam logic [1:0] ST_NO_JOB     = 2'd2;
   localparam logic [1:0] ST_TABLE_FULL = 2'd3;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_NEXT  = 2'd1;
   localparam logic [1:0] POL_BEST  = 2'd2;

   localparam logic [1:0] CSR_FIT_POLICY  = 2'd0;
   localparam logic [1:0] CSR_MEMORY_SIZE = 2'd1;

   typedef struct packed {
      logic [ADDR_BITS-1:0] start;
      logic [LEN_BITS-1:0]  length;
      logic                 used;
      logic [JOB_BITS-1:0]  owner;
   } part_entry_type;

   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
      part_entry_type      data;
   } ram_wr_type;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SCAN     = 9'b000000010,
      S_DECIDE   = 9'b000000100,
      S_SHIFT_UP = 9'b000001000,
      S_WR_SPLIT = 9'b000010000,
      S_WR_OWN   = 9'b000100000,
      S_WR_MERGE = 9'b001000000,
      S_SHIFT_DN = 9'b010000000,
      S_RESP     = 9'b100000000
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/core/vpa_table_ram.sv -----
// Partition table storage: one write port, one read port, registered read.
// Depends on vpa_pkg.
`default_nettype none
module vpa_table_ram (
   input  wire                                 clock,
   input  wire  vpa_pkg::ram_wr_type           wr,
   input  wire                                 rd_en,
   input  wire  [vpa_pkg::IDX_BITS-1:0]        rd_addr,
   output vpa_pkg::part_entry_type             rd_data
);
   import vpa_pkg::*;

   part_entry_type mem [MAX_PARTITIONS];
   part_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- rtl/core/variable_partition_allocator.sv -----
// Variable partition allocator top level: request sequencer and table RAM.
// Depends on vpa_pkg and vpa_table_ram.
//
// Usage:
//   req_ channel carries one word per request: command (allocate or free),
//   job_id and length_kb. rsp_ channel returns one word per request: status,
//   region_start and region_length. csr_ channel writes fit_policy (index 0)
//   or memory_size (index 1); a memory_size write reinitializes the table to
//   one free partition and clears the roving start. Writes are taken while
//   the block is idle and no request is offered.
//   Each request other than a zero-length allocation scans the table once
//   through the RAM read port, then allocations that split a partition
//   move the entries above it up one place and frees that merge move the
//   entries above the merge down. A zero-length allocation skips the scan
//   and answers directly. One request is in flight.
//   The result sits in an output register; a new request is accepted while
//   it waits, and the sequencer holds its next result until it is taken.
//   Reset (synchronous) writes the default single free partition in the
//   same cycle, so requests may follow right after reset.
`default_nettype none
module variable_partition_allocator (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_command,
   input  wire  [vpa_pkg::JOB_BITS-1:0]       req_job_id,
   input  wire  [vpa_pkg::KB_BITS-1:0]        req_length_kb,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [vpa_pkg::ADDR_BITS-1:0]      rsp_region_start,
   output logic [vpa_pkg::LEN_BITS-1:0]       rsp_region_length,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [1:0]                         csr_index,
   input  wire  [vpa_pkg::LEN_BITS-1:0]       csr_data
);
   import vpa_pkg::*;

   state_type state_ff, state_in;

   logic [1:0]           policy_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic [ADDR_BITS-1:0] rover_ff;

   logic                 cmd_ff;
   logic [JOB_BITS-1:0]  job_ff;
   logic [LEN_BITS-1:0]  req_len_ff;

   logic [CNT_BITS-1:0]  issue_ff;
   logic                 rd_vld_ff;
   logic [IDX_BITS-1:0]  rd_idx_ff;

   // allocation picks
   logic first_fnd_ff, rov_fnd_ff, best_fnd_ff;
   logic [IDX_BITS-1:0] first_idx_ff, rov_idx_ff, best_idx_ff;
   part_entry_type first_e_ff, rov_e_ff, best_e_ff;

   // free match and neighbors
   logic m_fnd_ff, grab_ff, right_ok_ff;
   logic [IDX_BITS-1:0] m_idx_ff;
   part_entry_type m_e_ff, left_e_ff, right_e_ff, prev_e_ff;

   logic [IDX_BITS-1:0]  p_idx_ff;
   part_entry_type       p_e_ff;
   logic [1:0]           gap_ff;
   logic [IDX_BITS-1:0]  lo_ff;

   logic [1:0]           res_status_ff;
   logic [ADDR_BITS-1:0] res_start_ff;
   logic [LEN_BITS-1:0]  res_length_ff;

   logic                 out_vld_ff;
   logic [1:0]           out_status_ff;
   logic [ADDR_BITS-1:0] out_start_ff;
   logic [LEN_BITS-1:0]  out_length_ff;

   ram_wr_type          wr, fsm_wr;
   logic                rd_en;
   logic [IDX_BITS-1:0] rd_addr;
   part_entry_type      rd_data;

   logic req_acc, csr_acc, csr_size_wr;
   logic [LEN_BITS-1:0] size_clamped;

   logic                pick_fnd;
   logic [IDX_BITS-1:0] pick_idx;
   part_entry_type      pick_e;
   logic                pick_split;

   logic                left_free, right_free;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !req_valid;
   assign req_acc   = req_valid && req_ready;
   assign csr_acc   = csr_valid && csr_ready;
   assign csr_size_wr = csr_acc && (csr_index == CSR_MEMORY_SIZE);

   assign rsp_valid         = out_vld_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_region_start  = out_start_ff;
   assign rsp_region_length = out_length_ff;

   // clamp the managed size into 1 .. 2^ADDR_BITS
   always_comb begin
      size_clamped = csr_data;
      if (csr_data == '0) begin
         size_clamped = LEN_BITS'(1);
      end else if (csr_data > MEMORY_LIMIT) begin
         size_clamped = MEMORY_LIMIT;
      end
   end

   // select the allocation pick by policy
   always_comb begin
      pick_fnd = first_fnd_ff;
      pick_idx = first_idx_ff;
      pick_e   = first_e_ff;
      if (policy_ff == POL_BEST) begin
         pick_fnd = best_fnd_ff;
         pick_idx = best_idx_ff;
         pick_e   = best_e_ff;
      end else if (policy_ff == POL_NEXT && rov_fnd_ff) begin
         pick_fnd = 1'b1;
         pick_idx = rov_idx_ff;
         pick_e   = rov_e_ff;
      end
      pick_split = pick_e.length > req_len_ff;
   end

   assign left_free  = (m_idx_ff != '0) && !left_e_ff.used;
   assign right_free = right_ok_ff && !right_e_ff.used;

   // RAM read and sequencer write ports
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = issue_ff[IDX_BITS-1:0];
      fsm_wr  = '0;
      unique case (state_ff)
         S_SCAN: begin
            rd_en = issue_ff < count_ff;
         end
         S_SHIFT_UP: begin
            rd_en = issue_ff > {1'b0, p_idx_ff};
            fsm_wr.en   = rd_vld_ff;
            fsm_wr.addr = rd_idx_ff + IDX_BITS'(1);
            fsm_wr.data = rd_data;
         end
         S_SHIFT_DN: begin
            rd_en = issue_ff < count_ff;
            fsm_wr.en   = rd_vld_ff;
            fsm_wr.addr = rd_idx_ff - IDX_BITS'(gap_ff);
            fsm_wr.data = rd_data;
         end
         S_WR_SPLIT: begin
            fsm_wr.en          = 1'b1;
            fsm_wr.addr        = p_idx_ff + IDX_BITS'(1);
            fsm_wr.data.start  = p_e_ff.start + req_len_ff[ADDR_BITS-1:0];
            fsm_wr.data.length = p_e_ff.length - req_len_ff;
            fsm_wr.data.used   = 1'b0;
            fsm_wr.data.owner  = '0;
         end
         S_WR_OWN: begin
            fsm_wr.en          = 1'b1;
            fsm_wr.addr        = p_idx_ff;
            fsm_wr.data.start  = p_e_ff.start;
            fsm_wr.data.length = req_len_ff;
            fsm_wr.data.used   = 1'b1;
            fsm_wr.data.owner  = job_ff;
         end
         S_WR_MERGE: begin
            fsm_wr.en          = 1'b1;
            fsm_wr.addr        = lo_ff;
            fsm_wr.data.start  = res_start_ff;
            fsm_wr.data.length = res_length_ff;
            fsm_wr.data.used   = 1'b0;
            fsm_wr.data.owner  = '0;
         end
         S_IDLE, S_DECIDE, S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // reset and size writes load the single free partition into entry 0
   always_comb begin
      wr = fsm_wr;
      if (reset || csr_size_wr) begin
         wr.en          = 1'b1;
         wr.addr        = '0;
         wr.data.start  = '0;
         wr.data.length = reset ? DEFAULT_MEMORY : size_clamped;
         wr.data.used   = 1'b0;
         wr.data.owner  = '0;
      end
   end

   vpa_table_ram u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_command == CMD_ALLOC && req_length_kb == '0) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (!rd_en && !rd_vld_ff) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (cmd_ff == CMD_FREE) begin
               state_in = m_fnd_ff ? S_WR_MERGE : S_RESP;
            end else if (!pick_fnd) begin
               state_in = S_RESP;
            end else if (pick_split) begin
               if (count_ff >= TABLE_DEPTH) begin
                  state_in = S_RESP;
               end else if (count_ff > ({1'b0, pick_idx} + CNT_BITS'(1))) begin
                  state_in = S_SHIFT_UP;
               end else begin
                  state_in = S_WR_SPLIT;
               end
            end else begin
               state_in = S_WR_OWN;
            end
         end
         S_SHIFT_UP: begin
            if (!rd_en && !rd_vld_ff) state_in = S_WR_SPLIT;
         end
         S_WR_SPLIT: state_in = S_WR_OWN;
         S_WR_OWN:   state_in = S_RESP;
         S_WR_MERGE: begin
            state_in = (gap_ff != '0) ? S_SHIFT_DN : S_RESP;
         end
         S_SHIFT_DN: begin
            if (!rd_en && !rd_vld_ff) state_in = S_RESP;
         end
         S_RESP: begin
            if (!out_vld_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         policy_ff  <= POL_FIRST;
         count_ff   <= CNT_BITS'(1);
         rover_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_en;
         if (csr_acc && csr_index == CSR_FIT_POLICY) policy_ff <= csr_data[1:0];
         if (csr_size_wr) begin
            count_ff <= CNT_BITS'(1);
            rover_ff <= '0;
         end
         if (state_ff == S_WR_SPLIT) count_ff <= count_ff + CNT_BITS'(1);
         if (state_ff == S_WR_OWN && policy_ff == POL_NEXT) rover_ff <= p_e_ff.start;
         if (state_ff == S_SHIFT_DN && state_in == S_RESP) begin
            count_ff <= count_ff - CNT_BITS'(gap_ff);
         end
         // output register: load on finish, drop on take
         if (state_ff == S_RESP && (!out_vld_ff || rsp_ready)) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_addr;
      if (rd_en) begin
         if (state_ff == S_SHIFT_UP) issue_ff <= issue_ff - CNT_BITS'(1);
         else                        issue_ff <= issue_ff + CNT_BITS'(1);
      end
      unique case (state_ff)
         S_IDLE: begin
            cmd_ff        <= req_command;
            job_ff        <= req_job_id;
            req_len_ff    <= {req_length_kb, KB_SHIFT'(0)};
            issue_ff      <= '0;
            first_fnd_ff  <= 1'b0;
            rov_fnd_ff    <= 1'b0;
            best_fnd_ff   <= 1'b0;
            m_fnd_ff      <= 1'b0;
            grab_ff       <= 1'b0;
            right_ok_ff   <= 1'b0;
            res_status_ff <= ST_OK;
            res_start_ff  <= '0;
            res_length_ff <= '0;
         end
         S_SCAN: begin
            if (rd_vld_ff) begin
               prev_e_ff <= rd_data;
               if (cmd_ff == CMD_ALLOC) begin
                  if (!rd_data.used && rd_data.length >= req_len_ff) begin
                     if (!first_fnd_ff) begin
                        first_fnd_ff <= 1'b1;
                        first_idx_ff <= rd_idx_ff;
                        first_e_ff   <= rd_data;
                     end
                     if (!rov_fnd_ff && rd_data.start >= rover_ff) begin
                        rov_fnd_ff <= 1'b1;
                        rov_idx_ff <= rd_idx_ff;
                        rov_e_ff   <= rd_data;
                     end
                     if (!best_fnd_ff || rd_data.length < best_e_ff.length) begin
                        best_fnd_ff <= 1'b1;
                        best_idx_ff <= rd_idx_ff;
                        best_e_ff   <= rd_data;
                     end
                  end
               end else begin
                  if (!m_fnd_ff && rd_data.used && rd_data.owner == job_ff) begin
                     m_fnd_ff  <= 1'b1;
                     m_idx_ff  <= rd_idx_ff;
                     m_e_ff    <= rd_data;
                     left_e_ff <= prev_e_ff;
                     grab_ff   <= 1'b1;
                  end else if (grab_ff) begin
                     right_e_ff  <= rd_data;
                     right_ok_ff <= 1'b1;
                     grab_ff     <= 1'b0;
                  end
               end
            end
         end
         S_DECIDE: begin
            if (cmd_ff == CMD_FREE) begin
               if (!m_fnd_ff) begin
                  res_status_ff <= ST_NO_JOB;
               end else begin
                  lo_ff         <= left_free ? (m_idx_ff - IDX_BITS'(1)) : m_idx_ff;
                  res_start_ff  <= left_free ? left_e_ff.start : m_e_ff.start;
                  res_length_ff <= m_e_ff.length
                                 + (left_free  ? left_e_ff.length  : LEN_BITS'(0))
                                 + (right_free ? right_e_ff.length : LEN_BITS'(0));
                  gap_ff        <= 2'(left_free) + 2'(right_free);
               end
            end else if (!pick_fnd) begin
               res_status_ff <= ST_NO_SPACE;
            end else if (pick_split && count_ff >= TABLE_DEPTH) begin
               res_status_ff <= ST_TABLE_FULL;
            end else begin
               p_idx_ff      <= pick_idx;
               p_e_ff        <= pick_e;
               res_start_ff  <= pick_e.start;
               res_length_ff <= req_len_ff;
               issue_ff      <= count_ff - CNT_BITS'(1);
            end
         end
         S_WR_MERGE: begin
            issue_ff <= {1'b0, lo_ff} + CNT_BITS'(1) + CNT_BITS'(gap_ff);
         end
         S_RESP: begin
            if (!out_vld_ff || rsp_ready) begin
               out_status_ff <= res_status_ff;
               out_start_ff  <= res_start_ff;
               out_length_ff <= res_length_ff;
            end
         end
         S_SHIFT_UP, S_WR_SPLIT, S_WR_OWN, S_SHIFT_DN: begin
         end
         default: begin
         end
      endcase
   end
endmodule
`default_nettype wire
